// ===== src/ctsa_pkg.sv =====
`default_nettype none
package ctsa_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 13;
	localparam int DOY_W   = 9;

	// reciprocal of 100 for the century test: q = (year * CENT_RECIP) >> CENT_SHIFT
	localparam int CENT_RECIP_W = 13;
	localparam int CENT_SHIFT   = 19;
	localparam int CENT_Q_W     = 8;
	localparam logic [CENT_RECIP_W-1:0] CENT_RECIP = 13'd5243;
	localparam logic [YEAR_W-1:0] CENT_YEARS = 14'd100;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;
	typedef logic [HOUR_W-1:0]  hour_t;
	typedef logic [DOY_W-1:0]   doy_t;

	// length of a month, with february as in a common year
	function automatic day_t month_len(input month_t m);
		day_t len;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	// days before the first of the month, common year
	function automatic doy_t month_start(input month_t m);
		doy_t st;
		case (m)
			4'd1:    st = 9'd0;
			4'd2:    st = 9'd31;
			4'd3:    st = 9'd59;
			4'd4:    st = 9'd90;
			4'd5:    st = 9'd120;
			4'd6:    st = 9'd151;
			4'd7:    st = 9'd181;
			4'd8:    st = 9'd212;
			4'd9:    st = 9'd243;
			4'd10:   st = 9'd273;
			4'd11:   st = 9'd304;
			4'd12:   st = 9'd334;
			default: st = 9'd0;
		endcase
		return st;
	endfunction

endpackage
`default_nettype wire

// ===== src/calendar_time_step_advance_top.sv =====
`default_nettype none
// calendar time-step advance
//
// command channel: an item (cur_year, cur_month, cur_day, cur_hour, step_len) transfers
// at a rising edge with start high and busy low. busy is tied low, so an item may be
// offered every cycle.
// result channel: new_year, new_month, new_day, new_hour and day_of_year are valid for
// exactly one cycle while done is high; the receiver takes them at the edge ending that
// cycle and cannot hold them off, so nothing ever backs up inside the block.
// each item passes the s1, s2 and s3 registers and then the result register;
// throughput: one item per cycle, set by the four-stage pipeline
//   s1 clamps the inputs and multiplies the year by the reciprocal of 100
//   s2 adds the step to the hour and finishes the gregorian leap test
//   s3 rolls the day into the next month and december into the next year
//   s4 looks up the cumulative month start for the day-of-year (divisible-by-4 rule)
// hour and step are fixed point with HOUR_FRAC_BITS fraction bits; the step is
// clamped to one day and the hour saturated below one day, so at most one day carry
// occurs.
// reset: arst_n clears the stage valid bits at once; items in flight are dropped and
// done stays low until a new item has gone through.
module calendar_time_step_advance_top #(
	parameter int HOUR_FRAC_BITS = 8
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire ctsa_pkg::year_t   cur_year,
	input  wire ctsa_pkg::month_t  cur_month,
	input  wire ctsa_pkg::day_t    cur_day,
	input  wire ctsa_pkg::hour_t   cur_hour,
	input  wire ctsa_pkg::hour_t   step_len,
	output logic                   done,
	output ctsa_pkg::year_t        new_year,
	output ctsa_pkg::month_t       new_month,
	output ctsa_pkg::day_t         new_day,
	output ctsa_pkg::hour_t        new_hour,
	output ctsa_pkg::doy_t         day_of_year
);
	import ctsa_pkg::*;

	// one day in hour units and the width needed to add two values below it
	localparam int DAY_UNITS = 24 << HOUR_FRAC_BITS;
	localparam int DU_W      = $clog2(DAY_UNITS + 1);
	localparam int SUM_W     = ((DU_W > HOUR_W) ? DU_W : HOUR_W) + 1;
	localparam logic [SUM_W-1:0] DAY_C = SUM_W'(DAY_UNITS);

	localparam int PROD_W = YEAR_W + CENT_RECIP_W;

	// the pipeline never stalls
	assign busy = 1'b0;

	wire accept = start & ~busy;

	// ---------------------------------------------------------------- stage 1
	// clamp the fields and form the century quotient
	logic              vld_s1;
	year_t             year_s1;
	month_t            month_s1;
	day_t              day_s1;
	logic [SUM_W-1:0]  hour_s1;
	logic [SUM_W-1:0]  step_s1;
	logic [CENT_Q_W-1:0] cq_s1;

	month_t            month_c;
	day_t              day_c;
	logic [SUM_W-1:0]  hour_c;
	logic [SUM_W-1:0]  step_c;
	logic [PROD_W-1:0] prod_c;

	always_comb begin
		month_c = cur_month;
		if (cur_month == '0)
			month_c = MONTH_JAN;
		else if (cur_month > MONTH_DEC)
			month_c = MONTH_DEC;
		day_c = (cur_day == '0) ? day_t'(1) : cur_day;
		hour_c = SUM_W'(cur_hour);
		if (hour_c >= DAY_C)
			hour_c = DAY_C - SUM_W'(1);
		step_c = SUM_W'(step_len);
		if (step_c > DAY_C)
			step_c = DAY_C;
		prod_c = PROD_W'(cur_year) * PROD_W'(CENT_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			year_s1  <= cur_year;
			month_s1 <= month_c;
			day_s1   <= day_c;
			hour_s1  <= hour_c;
			step_s1  <= step_c;
			cq_s1    <= prod_c[CENT_SHIFT +: CENT_Q_W];
		end
	end

	// ---------------------------------------------------------------- stage 2
	// hour add with day carry; gregorian leap test from year mod 4, 100 and 400
	logic              vld_s2;
	year_t             year_s2;
	month_t            month_s2;
	logic [DAY_W:0]    day_s2;
	hour_t             hour_s2;
	logic              leap_s2;

	logic [SUM_W-1:0]  sum_c;
	logic [SUM_W-1:0]  hsum_c;
	logic              carry_c;
	logic              cent_c;
	logic              leap_c;

	always_comb begin
		sum_c   = hour_s1 + step_s1;
		carry_c = (sum_c >= DAY_C);
		hsum_c  = carry_c ? (sum_c - DAY_C) : sum_c;
		// remainder by 100 is zero when q*100 gives back the year
		cent_c  = (year_t'(YEAR_W'(cq_s1) * CENT_YEARS) == year_s1);
		// a century is a leap year only when its quotient is a multiple of four
		leap_c  = (year_s1[1:0] == 2'b00) && !(cent_c && (cq_s1[1:0] != 2'b00));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			day_s2   <= {1'b0, day_s1} + (DAY_W+1)'(carry_c);
			hour_s2  <= hsum_c[HOUR_W-1:0];
			leap_s2  <= leap_c;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// day past the month end rolls into the next month, december into the next year
	logic              vld_s3;
	year_t             year_s3;
	month_t            month_s3;
	day_t              day_s3;
	hour_t             hour_s3;

	day_t              dm_c;
	logic              roll_c;

	always_comb begin
		if (month_s2 == MONTH_FEB)
			dm_c = leap_s2 ? day_t'(29) : day_t'(28);
		else
			dm_c = month_len(month_s2);
		roll_c = (day_s2 > {1'b0, dm_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			hour_s3 <= hour_s2;
			if (roll_c) begin
				day_s3 <= day_t'(day_s2 - {1'b0, dm_c});
				if (month_s2 == MONTH_DEC) begin
					month_s3 <= MONTH_JAN;
					year_s3  <= year_s2 + year_t'(1);
				end else begin
					month_s3 <= month_s2 + month_t'(1);
					year_s3  <= year_s2;
				end
			end else begin
				day_s3   <= day_s2[DAY_W-1:0];
				month_s3 <= month_s2;
				year_s3  <= year_s2;
			end
		end
	end

	// ---------------------------------------------------------------- stage 4
	// day of year with the plain divisible-by-4 leap rule, then the result register
	doy_t doy_c;

	always_comb begin
		doy_c = month_start(month_s3) + doy_t'(day_s3);
		if ((year_s3[1:0] == 2'b00) && (month_s3 >= MONTH_MAR))
			doy_c = doy_c + doy_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			new_year    <= year_s3;
			new_month   <= month_s3;
			new_day     <= day_s3;
			new_hour    <= hour_s3;
			day_of_year <= doy_c;
		end
	end

	// ---------------------------------------------------------------- checks
	// every transfer in is followed by done once it has passed the s1, s2 and s3 registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("result missing four cycles after a transfer");

	// a month carry always lands on the first days of the next month
	a_roll_day: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && roll_c) |=> (day_s3 != '0) && (day_s3 <= day_t'(4)))
		else $error("month carry left a bad day");

	// the month stays in the calendar range through the pipeline
	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (new_month >= MONTH_JAN) && (new_month <= MONTH_DEC))
		else $error("month out of range");

	// ordinal day stays within a leap year
	a_doy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (day_of_year != '0) && (day_of_year <= doy_t'(366)))
		else $error("day of year out of range");

endmodule
`default_nettype wire
